/* sv/kocnt_pkg.sv */
`timescale 1ns / 1ps

package kocnt_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUSH
	} state_t;

	localparam logic [1:0] OUTCOME_NEW   = 2'd0;
	localparam logic [1:0] OUTCOME_MATCH = 2'd1;
	localparam logic [1:0] OUTCOME_DROP  = 2'd2;

	localparam logic REG_ENTRY_LIMIT      = 1'b0;
	localparam logic REG_REPEAT_THRESHOLD = 1'b1;

	localparam logic [7:0] COUNT_MAX       = 8'd255;
	localparam logic [8:0] LIMIT_RESET     = 9'd256;
	localparam logic [7:0] THRESHOLD_RESET = 8'd3;

endpackage

/* sv/key_occurrence_counting_table_unit.sv */
`timescale 1ns / 1ps

// Counts occurrences of 64-bit keys in a table of TABLE_DEPTH entries. Each word is
// searched against the stored keys in insertion order, one entry per cycle from a
// single-port key and count memory pair with registered read data. A hit bumps the
// stored count (saturating at 255) and raises repeat_flag once the count is at or
// above repeat_threshold; a miss appends the key with count 1 while the fill is below
// min(entry_limit, TABLE_DEPTH), else the word is dropped. One word is in work at a
// time, and its search reads one memory entry per cycle through the filled entries
// until a hit or the end of the fill. The result register lets the next word enter
// while a result waits. The user must write configuration only while the unit is
// idle; the unit itself does not enforce this.
module key_occurrence_counting_table_unit #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        repeat_flag,
	output logic [7:0]  occurrences,
	output logic [1:0]  outcome,
	input  logic        wr_en,
	input  logic        wr_idx,
	input  logic [8:0]  wr_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = (FW > 9) ? FW : 9;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [63:0] key_mem [TABLE_DEPTH];
	logic [7:0]  cnt_mem [TABLE_DEPTH];

	kocnt_pkg::state_t state_q, state_d;

	logic [8:0]    entry_limit_q;
	logic [7:0]    threshold_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] idx_q;
	logic [63:0]   key_q;

	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic [63:0]   key_rd_s1;
	logic [7:0]    cnt_rd_s1;

	logic       res_flag_q;
	logic [7:0] res_cnt_q;
	logic [1:0] res_outcome_q;

	logic       out_valid_q;
	logic       out_flag_q;
	logic [7:0] out_cnt_q;
	logic [1:0] out_outcome_q;

	logic          accept;
	logic          rd_en;
	logic          hit;
	logic          miss;
	logic          room;
	logic          out_free;
	logic          push;
	logic [CW-1:0] lim;
	logic [7:0]    cnt_inc;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != kocnt_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign lim      = (CW'(entry_limit_q) > DEPTH_C) ? DEPTH_C : CW'(entry_limit_q);
	assign room     = CW'(fill_q) < lim;
	assign cnt_inc  = (cnt_rd_s1 == kocnt_pkg::COUNT_MAX) ? cnt_rd_s1 : cnt_rd_s1 + 8'd1;

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		hit     = 1'b0;
		miss    = 1'b0;
		push    = 1'b0;
		unique case (state_q)
			kocnt_pkg::ST_IDLE: begin
				if (in_valid) state_d = kocnt_pkg::ST_SCAN;
			end
			kocnt_pkg::ST_SCAN: begin
				hit   = vld_s1 && (key_rd_s1 == key_q);
				rd_en = !hit && (idx_q < fill_q);
				miss  = !hit && !vld_s1 && !(idx_q < fill_q);
				if (hit || miss) state_d = kocnt_pkg::ST_PUSH;
			end
			kocnt_pkg::ST_PUSH: begin
				push = out_free;
				if (out_free) state_d = kocnt_pkg::ST_IDLE;
			end
			default: state_d = kocnt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (miss && room) begin
			key_mem[fill_q[AW-1:0]] <= key_q;
			cnt_mem[fill_q[AW-1:0]] <= 8'd1;
		end else if (hit) begin
			cnt_mem[addr_s1] <= cnt_inc;
		end
		if (rd_en) begin
			key_rd_s1 <= key_mem[idx_q[AW-1:0]];
			cnt_rd_s1 <= cnt_mem[idx_q[AW-1:0]];
			addr_s1   <= idx_q[AW-1:0];
		end
		if (accept) key_q <= key;
		if (hit) begin
			res_flag_q    <= (cnt_inc >= threshold_q);
			res_cnt_q     <= cnt_inc;
			res_outcome_q <= kocnt_pkg::OUTCOME_MATCH;
		end else if (miss) begin
			res_flag_q    <= 1'b0;
			res_cnt_q     <= room ? 8'd1 : 8'd0;
			res_outcome_q <= room ? kocnt_pkg::OUTCOME_NEW : kocnt_pkg::OUTCOME_DROP;
		end
		if (push) begin
			out_flag_q    <= res_flag_q;
			out_cnt_q     <= res_cnt_q;
			out_outcome_q <= res_outcome_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= kocnt_pkg::ST_IDLE;
			entry_limit_q <= kocnt_pkg::LIMIT_RESET;
			threshold_q   <= kocnt_pkg::THRESHOLD_RESET;
			fill_q        <= '0;
			idx_q         <= '0;
			vld_s1        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (wr_idx)
					kocnt_pkg::REG_ENTRY_LIMIT:      entry_limit_q <= wr_data;
					kocnt_pkg::REG_REPEAT_THRESHOLD: threshold_q   <= wr_data[7:0];
					default: ;
				endcase
			end
			if (miss && room) fill_q <= fill_q + FW'(1);
			if (accept) idx_q <= '0;
			else if (rd_en) idx_q <= idx_q + FW'(1);
			vld_s1 <= rd_en;
			if (push) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign repeat_flag = out_flag_q;
	assign occurrences = out_cnt_q;
	assign outcome     = out_outcome_q;

endmodule

/* dv/kocnt_checker.sv */
`timescale 1ns / 1ps

module kocnt_checker #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] key,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        repeat_flag,
	input  logic [7:0]  occurrences,
	input  logic [1:0]  outcome,
	input  logic        wr_en,
	input  logic        wr_idx,
	input  logic [8:0]  wr_data,
	output int          mismatches,
	output int          outstanding,
	output int          new_cnt,
	output int          match_cnt,
	output int          drop_cnt,
	output int          sat_cnt
);

	typedef struct packed {
		logic       flag;
		logic [7:0] occ;
		logic [1:0] outcome;
	} tally_t;

	logic [63:0] key_mem [TABLE_DEPTH];
	logic [7:0]  cnt_mem [TABLE_DEPTH];
	int unsigned fill;
	logic [8:0]  limit_reg;
	logic [7:0]  thr_reg;
	tally_t      due_tallies [$];
	int          n_bad;
	int          n_new;
	int          n_match;
	int          n_drop;
	int          n_sat;

	function automatic tally_t count_key(input logic [63:0] k);
		tally_t      t;
		int unsigned lim;
		int          hit;
		lim = (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
		hit = -1;
		for (int i = 0; i < fill; i++) begin
			if (hit < 0 && key_mem[i] == k)
				hit = i;
		end
		if (hit >= 0) begin
			if (cnt_mem[hit] != kocnt_pkg::COUNT_MAX)
				cnt_mem[hit] = cnt_mem[hit] + 8'd1;
			t.flag    = (cnt_mem[hit] >= thr_reg);
			t.occ     = cnt_mem[hit];
			t.outcome = kocnt_pkg::OUTCOME_MATCH;
		end else if (fill < lim) begin
			key_mem[fill] = k;
			cnt_mem[fill] = 8'd1;
			fill++;
			t = '{1'b0, 8'd1, kocnt_pkg::OUTCOME_NEW};
		end else begin
			t = '{1'b0, 8'd0, kocnt_pkg::OUTCOME_DROP};
		end
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tally_t got;
		tally_t want;
		if (!arst_n) begin
			fill      = 0;
			limit_reg = kocnt_pkg::LIMIT_RESET;
			thr_reg   = kocnt_pkg::THRESHOLD_RESET;
			due_tallies.delete();
			n_bad   = 0;
			n_new   = 0;
			n_match = 0;
			n_drop  = 0;
			n_sat   = 0;
		end else begin
			if (wr_en) begin
				case (wr_idx)
					kocnt_pkg::REG_ENTRY_LIMIT:      limit_reg = wr_data;
					kocnt_pkg::REG_REPEAT_THRESHOLD: thr_reg = wr_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{repeat_flag, occurrences, outcome};
				if (due_tallies.size() == 0) begin
					if (n_bad < 10)
						$display("%0t: unexpected word, flag %0d occurrences %0d outcome %0d",
							$time, got.flag, got.occ, got.outcome);
					n_bad++;
				end else begin
					want = due_tallies.pop_front();
					if (got !== want) begin
						if (n_bad < 10)
							$display("%0t: word mismatch, expected %0d/%0d/%0d got %0d/%0d/%0d",
								$time, want.flag, want.occ, want.outcome,
								got.flag, got.occ, got.outcome);
						n_bad++;
					end
					case (want.outcome)
						kocnt_pkg::OUTCOME_NEW:   n_new++;
						kocnt_pkg::OUTCOME_MATCH: n_match++;
						default:                  n_drop++;
					endcase
					if (want.occ == kocnt_pkg::COUNT_MAX)
						n_sat++;
				end
			end
			if (in_valid && !in_stall)
				due_tallies.push_back(count_key(key));
		end
		mismatches  <= n_bad;
		outstanding <= due_tallies.size();
		new_cnt     <= n_new;
		match_cnt   <= n_match;
		drop_cnt    <= n_drop;
		sat_cnt     <= n_sat;
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int TABLE_DEPTH  = 256;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
	localparam int HOLD_CYCLES  = 1500;
	localparam logic [63:0] ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] ALT_5 = 64'h5555_5555_5555_5555;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [63:0] key       = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        repeat_flag;
	logic [7:0]  occurrences;
	logic [1:0]  outcome;
	logic        wr_en     = 1'b0;
	logic        wr_idx    = kocnt_pkg::REG_ENTRY_LIMIT;
	logic [8:0]  wr_data   = '0;

	int mismatches;
	int outstanding;
	int new_cnt;
	int match_cnt;
	int drop_cnt;
	int sat_cnt;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          holds_asked   = 0;
	logic [63:0] hot_key       = ALT_A;
	logic [63:0] seen_keys [$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	key_occurrence_counting_table_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key        (key),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.repeat_flag(repeat_flag),
		.occurrences(occurrences),
		.outcome    (outcome),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data)
	);

	kocnt_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) tally_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key        (key),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.repeat_flag(repeat_flag),
		.occurrences(occurrences),
		.outcome    (outcome),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.new_cnt    (new_cnt),
		.match_cnt  (match_cnt),
		.drop_cnt   (drop_cnt),
		.sat_cnt    (sat_cnt)
	);

	initial begin : receiver
		int holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_asked > holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic send_word(input logic [63:0] k);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		key      <= k;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [8:0] lim, input logic [8:0] thr);
		wr_en   <= 1'b1;
		wr_idx  <= kocnt_pkg::REG_ENTRY_LIMIT;
		wr_data <= lim;
		@(posedge clk);
		wr_idx  <= kocnt_pkg::REG_REPEAT_THRESHOLD;
		wr_data <= thr;
		@(posedge clk);
		wr_en   <= 1'b0;
	endtask

	// mostly the hot key (drives it to saturation), near misses, reuse, fresh keys
	task automatic random_words(input int count, input bit mid_hold, input bit mid_pause);
		logic [63:0] k;
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62)
				k = hot_key;
			else if (pick < 67)
				k = hot_key ^ (64'd1 << $urandom_range(0, 63));
			else if (pick < 80)
				k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
			else begin
				k = {$urandom, $urandom};
				seen_keys.push_back(k);
			end
			send_word(k);
			if (i == count / 2) begin
				if (mid_hold)
					holds_asked <= holds_asked + 1;
				if (mid_pause)
					drain();
			end
		end
	endtask

	initial begin : stimulus
		seen_keys.push_back(64'd0);
		seen_keys.push_back('1);
		seen_keys.push_back(ALT_A);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 32;
		recv_idle_pct = 73;

		// zero limit on an empty table: everything drops
		set_config(9'd0, 9'd1);
		send_word('1);
		send_word(64'd0);
		drain();
		// threshold written with bit 8 set reads back as 1
		set_config(9'd2, 9'h101);
		send_word(64'd0);
		send_word(64'd0);
		send_word('1);
		send_word(ALT_5);
		drain();
		// limit below fill, zero threshold
		set_config(9'd1, 9'd0);
		send_word('1);
		send_word(ALT_A);
		drain();
		set_config(9'd511, 9'd255);
		send_word(ALT_A);
		send_word(ALT_A);
		send_word(64'd0);
		send_word(64'h8000_0000_0000_0000);
		send_word(64'd1);
		drain();

		set_config(9'd256, 9'd3);
		random_words(150, 1'b1, 1'b0);
		drain();

		send_idle_pct = 73;
		recv_idle_pct = 32;
		set_config(9'($urandom_range(30, 70)), 9'($urandom_range(1, 254)));
		random_words(150, 1'b0, 1'b0);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(9'd511, 9'd255);
		random_words(150, 1'b0, 1'b1);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d words: %0d stored, %0d matched, %0d dropped, %0d at count 255.",
			new_cnt + match_cnt + drop_cnt, new_cnt, match_cnt, drop_cnt, sat_cnt);
		$display("Limits 0..511 and thresholds 0..255 under three idle mixes and a %0d-cycle hold.",
			HOLD_CYCLES);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#20ms;
		$display("Timeout with %0d words outstanding", outstanding);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
